// File: rtl/core/skm_pkg.sv
// Shared types, constants and keyword table for the secret key name matcher.
package skm_pkg;

    localparam int WINDOW_BYTES = 13;
    localparam int KW_COUNT     = 19;
    localparam int KW_MAX       = 13;
    localparam int COUNT_W      = 4;
    localparam int WIN_IDX_W    = $clog2(WINDOW_BYTES);
    localparam int KW_IDX_W     = $clog2(KW_COUNT);

    localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;
    localparam logic [7:0] UPPER_A  = 8'h41;
    localparam logic [7:0] UPPER_Z  = 8'h5A;
    localparam logic [7:0] FOLD_BIT = 8'h20;
    localparam logic [7:0] DOT_BYTE = 8'h2E;

    typedef logic [WINDOW_BYTES-1:0][7:0] t_window;

    typedef struct packed {
        t_window              window;
        logic [COUNT_W-1:0]   count;
        logic                 dot;
    } t_key_state;

    // keyword text is right aligned: final character in bits [7:0]
    localparam logic [COUNT_W-1:0] KW_LEN [KW_COUNT] = '{
        4'd5,
        4'd6, 4'd6, 4'd6, 4'd6,
        4'd7, 4'd7,
        4'd8, 4'd8,
        4'd10, 4'd10, 4'd10, 4'd10,
        4'd11, 4'd11,
        4'd12,
        4'd13, 4'd13, 4'd13
    };

    localparam logic [KW_MAX*8-1:0] KW_TEXT [KW_COUNT] = '{
        "token",
        "apikey", "cookie", "passwd", "secret",
        "api_key", "session",
        104'h69645f746f6b656e, "password",
        "passphrase", 104'h73657373696f6e5f6964, 104'h7365745f636f6f6b6965,
        104'h7365637265745f6b6579,
        104'h707269766174655f6b6579, 104'h7369676e696e675f6b6579,
        104'h6163636573735f746f6b656e,
        "authorization", 104'h636c69656e745f736563726574,
        104'h726566726573685f746f6b656e
    };

    function automatic logic [7:0] f_fold(logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= UPPER_A && b <= UPPER_Z) begin
            r = b | FOLD_BIT;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/skm_window.sv
// Folded byte window, saturating length count and dot flag of the current key.
module skm_window (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_key_byte,
    input  logic                  i_byte_present,
    input  logic                  i_last,
    output skm_pkg::t_key_state   o_next
);
    import skm_pkg::*;

    t_window              r_window;
    logic [COUNT_W-1:0]   r_count;
    logic                 r_dot;
    t_key_state           n_state;

    always_comb begin
        n_state.window = r_window;
        n_state.count  = r_count;
        n_state.dot    = r_dot;
        if (i_byte_present) begin
            n_state.window = {r_window[WINDOW_BYTES-2:0], f_fold(i_key_byte)};
            if (r_count != COUNT_MAX) begin
                n_state.count = r_count + 1'b1;
            end
            if (i_key_byte == DOT_BYTE) begin
                n_state.dot = 1'b1;
            end
        end
    end

    assign o_next = n_state;

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_window <= n_state.window;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_dot   <= 1'b0;
        end else if (i_accept) begin
            if (i_last) begin
                r_count <= '0;
                r_dot   <= 1'b0;
            end else begin
                r_count <= n_state.count;
                r_dot   <= n_state.dot;
            end
        end
    end

endmodule

// File: rtl/core/skm_keyword_match.sv
// Parallel compare of the window tail against the keyword table.
module skm_keyword_match (
    input  skm_pkg::t_key_state   i_state,
    output logic                  o_match
);
    import skm_pkg::*;

    logic [KW_COUNT-1:0] hit;

    always_comb begin
        for (int k = 0; k < KW_COUNT; k++) begin
            hit[KW_IDX_W'(k)] = (i_state.count == KW_LEN[KW_IDX_W'(k)]) ||
                                (i_state.dot && (i_state.count > KW_LEN[KW_IDX_W'(k)]));
            for (int i = 0; i < KW_MAX; i++) begin
                if (i < int'(KW_LEN[KW_IDX_W'(k)]) &&
                    i_state.window[WIN_IDX_W'(i)] != KW_TEXT[KW_IDX_W'(k)][i*8 +: 8]) begin
                    hit[KW_IDX_W'(k)] = 1'b0;
                end
            end
        end
    end

    assign o_match = |hit;

endmodule

// File: rtl/core/secret_key_name_matcher_core.sv
// Top level of the secret key name matcher: byte input, one redact result per key.
// Result: registered; the result of a key appears in the cycle after its last item is accepted.
// Throughput: one item per cycle; the input stalls only while a result is held.
// Reset: synchronous active low; clears length count, dot flag and output valid.
// Window shift, case fold and keyword compare all sit between state and result register.
module secret_key_name_matcher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_key_byte,
    input  logic        i_byte_present,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_redact
);
    import skm_pkg::*;

    t_key_state   next_state;
    logic         match;
    logic         accept;
    logic         r_out_valid;
    logic         r_redact;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    skm_window u_window (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_key_byte     (i_key_byte),
        .i_byte_present (i_byte_present),
        .i_last         (i_last),
        .o_next         (next_state)
    );

    skm_keyword_match u_match (
        .i_state (next_state),
        .o_match (match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_out_valid <= accept && i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_last) begin
            r_redact <= match;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_redact    = r_redact;

endmodule

// File: rtl/core/skm_checker.sv
// Port-level checker for the secret key name matcher, bound to the top level.
module skm_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        o_in_stall,
    input  logic        i_last,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic        o_redact
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_redact_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_redact))
        else $error("redact changed while stalled");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_last |=> o_out_valid)
        else $error("no result after last item");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !i_last |=> !o_out_valid)
        else $error("result without last item");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without held result");

endmodule

bind secret_key_name_matcher_core skm_checker u_skm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_last         (i_last),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_redact       (o_redact)
);

// File: test/tb_secret_key_name_matcher_core.sv
// Self-checking testbench for the secret key name matcher core.
module tb_secret_key_name_matcher_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1800;
    localparam int CALM_FROM    = 1600;
    localparam logic [7:0] DOT  = skm_pkg::DOT_BYTE;

    class redact_scoreboard;
        string       words[19];
        logic [7:0]  tail[$];
        int unsigned key_len;
        bit          dot;
        bit          pending_redact[$];
        int          errors;
        int          keys;
        int          flagged;

        function new();
            words = '{"token", "apikey", "cookie", "passwd", "secret", "api_key",
                      "session", {"id", "_token"}, "password", "passphrase",
                      {"session", "_id"}, {"set", "_cookie"}, {"secret", "_key"},
                      {"private", "_key"}, {"signing", "_key"}, {"access", "_token"},
                      "authorization", {"client", "_secret"}, {"refresh", "_token"}};
            key_len = 0;
            dot     = 0;
            errors  = 0;
            keys    = 0;
            flagged = 0;
        endfunction

        function bit tail_is(string w);
            int n;
            n = w.len();
            for (int i = 0; i < n; i++) begin
                if (tail[tail.size() - n + i] != w.getc(i)) return 0;
            end
            return 1;
        endfunction

        function bit key_hits();
            int n;
            foreach (words[k]) begin
                n = words[k].len();
                if ((key_len == n || (dot && key_len > n)) && tail_is(words[k])) return 1;
            end
            return 0;
        endfunction

        function void note_item(logic [7:0] b, logic present, logic last);
            logic [7:0] f;
            if (present) begin
                f = (b >= 8'h41 && b <= 8'h5A) ? (b | 8'h20) : b;
                tail.push_back(f);
                if (tail.size() > skm_pkg::WINDOW_BYTES) void'(tail.pop_front());
                if (key_len < skm_pkg::COUNT_MAX) key_len++;
                if (b == DOT) dot = 1;
            end
            if (last) begin
                pending_redact.push_back(key_hits());
                tail.delete();
                key_len = 0;
                dot     = 0;
            end
        endfunction

        function void check_result(logic actual);
            bit want;
            if (pending_redact.size() == 0) begin
                $error("redact: no result expected, actual %b", actual);
                errors++;
                return;
            end
            want = pending_redact.pop_front();
            keys++;
            if (want) flagged++;
            if (actual !== want) begin
                $error("redact mismatch: expected %0b, actual %b", want, actual);
                errors++;
            end
        endfunction

        function int pending();
            return pending_redact.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_key_byte;
    logic       i_byte_present;
    logic       i_last;
    logic       o_out_valid;
    logic       i_out_stall;
    logic       o_redact;

    redact_scoreboard sb;
    logic [7:0]       key_buf[$];
    int               item_count;
    int               gap_odds;
    int               stall_odds;
    int               idle_cycles;
    bit               paused;

    secret_key_name_matcher_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_key_byte     (i_key_byte),
        .i_byte_present (i_byte_present),
        .i_last         (i_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_redact       (o_redact)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.note_item(i_key_byte, i_byte_present, i_last);
            if (o_out_valid && !i_out_stall) sb.check_result(o_redact);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side back-pressure in random bursts
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic int pick_odds();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 2;
            2: return 5;
            default: return 20;
        endcase
    endfunction

    function automatic logic [7:0] mixed_case(logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1) return c & ~8'h20;
        return c;
    endfunction

    function automatic logic [7:0] filler_char(bit allow_dot);
        int r;
        logic [7:0] c;
        r = $urandom_range(0, 9);
        if (r <= 5) return mixed_case(8'h61 + 8'($urandom_range(0, 25)));
        if (r == 6) return 8'h5F;
        if (r == 7) return 8'h30 + 8'($urandom_range(0, 9));
        if (r == 8) return allow_dot ? DOT : 8'h2D;
        c = 8'($urandom_range(0, 255));
        if (!allow_dot && c == DOT) c = 8'h2F;
        return c;
    endfunction

    task automatic send_item(logic [7:0] b, logic p, logic l);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_key_byte     <= b;
        i_byte_present <= p;
        i_last         <= l;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (p || l) item_count++;
    endtask

    task automatic send_key(bit split_end);
        int n;
        n = key_buf.size();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 11) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(key_buf[i], 1'b1, (i == n - 1) && !split_end);
        end
        if (split_end || n == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic load_text(string s);
        key_buf.delete();
        for (int i = 0; i < s.len(); i++) key_buf.push_back(s.getc(i));
    endtask

    // mostly keyword based keys: exact, dotted prefix, plain prefix, near misses, noise
    task automatic build_random_key();
        int    mode;
        int    n;
        int    pos;
        string w;
        key_buf.delete();
        mode = $urandom_range(0, 9);
        w    = sb.words[$urandom_range(0, 18)];
        if (mode >= 8) begin
            n = $urandom_range(0, 20);
            for (int i = 0; i < n; i++) begin
                key_buf.push_back(mode == 8 ? 8'($urandom_range(0, 255)) : filler_char(1));
            end
            return;
        end
        if (mode >= 3) begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) key_buf.push_back(filler_char(mode != 5));
            if (mode == 3 || mode == 4) key_buf[$urandom_range(0, n - 1)] = DOT;
        end
        pos = key_buf.size();
        for (int i = 0; i < w.len(); i++) key_buf.push_back(mixed_case(w.getc(i)));
        if (mode == 6) key_buf[pos + $urandom_range(0, w.len() - 1)] = 8'($urandom_range(0, 255));
        if (mode == 7) begin
            if ($urandom_range(0, 1) == 1) key_buf.push_back(filler_char(1));
            else void'(key_buf.pop_back());
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    initial begin
        sb             = new();
        item_count     = 0;
        gap_odds       = 0;
        stall_odds     = 0;
        paused         = 0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_key_byte     = 8'h00;
        i_byte_present = 1'b0;
        i_last         = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle item, mixed case exact match, empty key, dot with split end, saturated length
        send_item(8'hFF, 1'b0, 1'b0);
        load_text("tOkEn");
        send_key(0);
        send_item(8'h00, 1'b0, 1'b1);
        load_text(".token");
        send_key(1);
        load_text("x.AUTHORIZATION");
        send_key(0);
        wait_drained();

        gap_odds   = 5;
        stall_odds = 5;
        while (item_count < RANDOM_ITEMS) begin
            if ($urandom_range(0, 39) == 0) begin
                gap_odds   = pick_odds();
                stall_odds = pick_odds();
            end
            if (item_count >= CALM_FROM) begin
                gap_odds   = 0;
                stall_odds = 0;
            end
            if (!paused && item_count >= RANDOM_ITEMS / 2) begin
                wait_drained();
                paused = 1;
            end
            build_random_key();
            send_key($urandom_range(0, 3) == 0);
        end
        wait_drained();
        repeat (4) @(posedge i_clk);

        $display("Checked %0d keys (%0d flagged for redaction) from %0d key items,",
                 sb.keys, sb.flagged, item_count);
        $display("covering exact, dotted suffix, near-miss, empty and saturated keys.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
